>>> design/assert_macros.svh
// Assertion macros shared by the Morse codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define MC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/mc_pkg.sv
// Shared types, character codes and tree tables of the Morse codec.
package mc_pkg;

	// Character codes.
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// First node of the deepest level; a symbol there overflows the code.
	localparam logic [5:0] DEEPEST_FIRST = 6'd31;
	localparam logic [5:0] ROOT = 6'd0;

	// Function codes of the input transaction.
	localparam logic FUNC_DECODE = 1'b0;
	localparam logic FUNC_ENCODE = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] in_char;
		logic       followed_by_space;
		logic       end_of_message;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       error;
	} rsp_t;

	// Work for the back end: an optional leading character, up to five
	// dot/dash symbols (left aligned, 1 is a dash) and an optional space.
	typedef struct packed {
		logic       head_v;
		logic [7:0] head_char;
		logic       head_err;
		logic [2:0] sym_len;
		logic [4:0] sym_code;
		logic       tail_v;
	} job_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic avail;
		logic full;
	} qstat_t;

	function automatic logic job_empty(input job_t j);
		return !j.head_v && (j.sym_len == 3'd0) && !j.tail_v;
	endfunction

	// Character held by each tree node; placeholders read as underscore.
	function automatic logic [7:0] node_char(input logic [5:0] idx);
		logic [7:0] c;
		case (idx)
			6'd0:    c = CH_STAR;
			6'd1:    c = "E";
			6'd2:    c = "T";
			6'd3:    c = "I";
			6'd4:    c = "A";
			6'd5:    c = "N";
			6'd6:    c = "M";
			6'd7:    c = "S";
			6'd8:    c = "U";
			6'd9:    c = "R";
			6'd10:   c = "W";
			6'd11:   c = "D";
			6'd12:   c = "K";
			6'd13:   c = "G";
			6'd14:   c = "O";
			6'd15:   c = "H";
			6'd16:   c = "V";
			6'd17:   c = "F";
			6'd19:   c = "L";
			6'd21:   c = "P";
			6'd22:   c = "J";
			6'd23:   c = "B";
			6'd24:   c = "X";
			6'd25:   c = "C";
			6'd26:   c = "Y";
			6'd27:   c = "Z";
			6'd28:   c = "Q";
			6'd31:   c = "5";
			6'd32:   c = "4";
			6'd34:   c = "3";
			6'd38:   c = "2";
			6'd46:   c = "1";
			6'd47:   c = "6";
			6'd55:   c = "7";
			6'd59:   c = "8";
			6'd61:   c = "9";
			6'd62:   c = "0";
			default: c = CH_UNDER;
		endcase
		return c;
	endfunction

	// Node index of an upper-case letter or digit; the top bit flags a hit.
	function automatic logic [6:0] char_node(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			"E":     r = {1'b1, 6'd1};
			"T":     r = {1'b1, 6'd2};
			"I":     r = {1'b1, 6'd3};
			"A":     r = {1'b1, 6'd4};
			"N":     r = {1'b1, 6'd5};
			"M":     r = {1'b1, 6'd6};
			"S":     r = {1'b1, 6'd7};
			"U":     r = {1'b1, 6'd8};
			"R":     r = {1'b1, 6'd9};
			"W":     r = {1'b1, 6'd10};
			"D":     r = {1'b1, 6'd11};
			"K":     r = {1'b1, 6'd12};
			"G":     r = {1'b1, 6'd13};
			"O":     r = {1'b1, 6'd14};
			"H":     r = {1'b1, 6'd15};
			"V":     r = {1'b1, 6'd16};
			"F":     r = {1'b1, 6'd17};
			"L":     r = {1'b1, 6'd19};
			"P":     r = {1'b1, 6'd21};
			"J":     r = {1'b1, 6'd22};
			"B":     r = {1'b1, 6'd23};
			"X":     r = {1'b1, 6'd24};
			"C":     r = {1'b1, 6'd25};
			"Y":     r = {1'b1, 6'd26};
			"Z":     r = {1'b1, 6'd27};
			"Q":     r = {1'b1, 6'd28};
			"5":     r = {1'b1, 6'd31};
			"4":     r = {1'b1, 6'd32};
			"3":     r = {1'b1, 6'd34};
			"2":     r = {1'b1, 6'd38};
			"1":     r = {1'b1, 6'd46};
			"6":     r = {1'b1, 6'd47};
			"7":     r = {1'b1, 6'd55};
			"8":     r = {1'b1, 6'd59};
			"9":     r = {1'b1, 6'd61};
			"0":     r = {1'b1, 6'd62};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

>>> design/mc_front.sv
// Front end: accepts requests, walks the decode tree and builds back-end jobs.
`include "assert_macros.svh"

module mc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mc_pkg::req_t   req,
	input  mc_pkg::qstat_t qstat,
	output logic           push,
	output mc_pkg::job_t   job
);

	logic [5:0]   pos_q;
	logic [5:0]   pos_d;
	logic [5:0]   child;
	logic [7:0]   uc;
	logic [6:0]   hit_idx;
	logic [5:0]   path;
	logic         accept;

	assign req_stall = qstat.full;
	assign accept    = req_valid && !qstat.full;
	assign push      = accept && !mc_pkg::job_empty(job);

	// Child node reached by a dot or a dash; only used above the deepest level.
	assign child = {pos_q[4:0], 1'b0} + ((req.in_char == mc_pkg::CH_DOT) ? 6'd1 : 6'd2);

	// Upper-case the text character and look it up in the tree.
	assign uc      = (req.in_char inside {["a":"z"]}) ? (req.in_char - 8'd32) : req.in_char;
	assign hit_idx = mc_pkg::char_node(uc);
	assign path    = hit_idx[5:0] + 6'd1;

	// Classify the request and form its job.
	always_comb begin
		job   = '0;
		pos_d = pos_q;
		if (req.func == mc_pkg::FUNC_DECODE) begin
			if (req.in_char == mc_pkg::CH_DOT || req.in_char == mc_pkg::CH_DASH) begin
				if (pos_q >= mc_pkg::DEEPEST_FIRST) begin
					job.head_v    = 1'b1;
					job.head_char = mc_pkg::CH_NUL;
					job.head_err  = 1'b1;
					pos_d         = mc_pkg::ROOT;
				end else if (req.end_of_message) begin
					job.head_v    = 1'b1;
					job.head_char = mc_pkg::node_char(child);
					pos_d         = mc_pkg::ROOT;
				end else begin
					pos_d = child;
				end
			end else if (req.in_char == mc_pkg::CH_SPACE ||
					req.in_char == mc_pkg::CH_SLASH) begin
				if (pos_q != mc_pkg::ROOT) begin
					job.head_v    = 1'b1;
					job.head_char = mc_pkg::node_char(pos_q);
					job.tail_v    = (req.in_char == mc_pkg::CH_SLASH);
					pos_d         = mc_pkg::ROOT;
				end
			end else if (req.end_of_message && pos_q != mc_pkg::ROOT) begin
				job.head_v    = 1'b1;
				job.head_char = mc_pkg::node_char(pos_q);
				pos_d         = mc_pkg::ROOT;
			end
		end else begin
			if (uc == mc_pkg::CH_SPACE) begin
				job.head_v    = 1'b1;
				job.head_char = mc_pkg::CH_SLASH;
			end else begin
				job.tail_v = !req.followed_by_space;
				if (uc == mc_pkg::CH_STAR || uc == mc_pkg::CH_UNDER) begin
					job.head_v    = 1'b1;
					job.head_char = uc;
				end else if (hit_idx[6]) begin
					// The bits of node+1 below its leading one spell the code.
					if (path[5]) begin
						job.sym_len  = 3'd5;
						job.sym_code = path[4:0];
					end else if (path[4]) begin
						job.sym_len  = 3'd4;
						job.sym_code = {path[3:0], 1'b0};
					end else if (path[3]) begin
						job.sym_len  = 3'd3;
						job.sym_code = {path[2:0], 2'b0};
					end else if (path[2]) begin
						job.sym_len  = 3'd2;
						job.sym_code = {path[1:0], 3'b0};
					end else begin
						job.sym_len  = 3'd1;
						job.sym_code = {path[0], 4'b0};
					end
				end
			end
		end
	end

	// Tree position moves only on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= mc_pkg::ROOT;
		end else if (accept) begin
			pos_q <= pos_d;
		end
	end

	`MC_ASSERT(a_pos_in_tree, pos_q != 6'd63, "tree position left the 63-node tree")
	`MC_ASSERT_IMP(a_no_push_full, push, !qstat.full, "job pushed into a full queue")

endmodule

>>> design/mc_queue.sv
// Two-entry job queue between the front end and the back end.
`include "assert_macros.svh"

module mc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mc_pkg::job_t   push_job,
	input  logic           pop,
	output mc_pkg::job_t   head_job,
	output mc_pkg::qstat_t qstat
);

	mc_pkg::job_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_pop;

	assign qstat.avail = (count_q != 2'd0);
	assign qstat.full  = (count_q == 2'd2);
	assign head_job    = slot_q[rd_ptr_q];
	assign do_pop      = pop && qstat.avail;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	`MC_ASSERT(a_count_range, count_q <= 2'd2, "queue fill count out of range")

endmodule

>>> design/mc_back.sv
// Back end: plays out each job one character per cycle, unless the output is stalled, into the output register.
`include "assert_macros.svh"

module mc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mc_pkg::qstat_t qstat,
	input  mc_pkg::job_t   head_job,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mc_pkg::rsp_t   rsp
);

	mc_pkg::job_t cur_q;
	logic         busy_q;
	logic         out_valid_q;
	mc_pkg::rsp_t rsp_q;

	mc_pkg::job_t view;
	mc_pkg::job_t nxt;
	logic         view_v;
	logic         advance;
	logic         last;
	mc_pkg::rsp_t emit;

	assign view    = busy_q ? cur_q : head_job;
	assign view_v  = busy_q || qstat.avail;
	assign advance = !out_valid_q || !rsp_stall;
	assign pop     = advance && !busy_q && qstat.avail;

	// Next character of the job, and what remains of it.
	always_comb begin
		nxt  = view;
		emit = '0;
		if (view.head_v) begin
			emit.out_char = view.head_char;
			emit.error    = view.head_err;
			nxt.head_v    = 1'b0;
		end else if (view.sym_len != 3'd0) begin
			emit.out_char = view.sym_code[4] ? mc_pkg::CH_DASH : mc_pkg::CH_DOT;
			nxt.sym_code  = {view.sym_code[3:0], 1'b0};
			nxt.sym_len   = view.sym_len - 3'd1;
		end else begin
			emit.out_char = mc_pkg::CH_SPACE;
			nxt.tail_v    = 1'b0;
		end
		last             = mc_pkg::job_empty(nxt);
		emit.last_of_run = last;
	end

	// Control: job in progress and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			busy_q      <= view_v && !last;
			out_valid_q <= view_v;
		end
	end

	// Payload: remaining job and the output transaction.
	always_ff @(posedge clk) begin
		if (advance && view_v) begin
			cur_q <= nxt;
			rsp_q <= emit;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	`MC_ASSERT_IMP(a_busy_has_work, busy_q, !mc_pkg::job_empty(cur_q),
		"back end busy with an empty job")
	`MC_ASSERT_IMP(a_pop_nonempty, pop, !mc_pkg::job_empty(head_job),
		"empty job taken from the queue")

endmodule

>>> design/morse_codec_top.sv
// Top level of the Morse codec: front end, job queue and back end.
//
//   channel   valid       stall       payload             direction
//   request   req_valid   req_stall   req (req_t)         into the block
//   result    rsp_valid   rsp_stall   rsp (rsp_t)         out of the block
//
// A request is classified and its tree position updated in the cycle it is accepted;
// a request with no result pushes no job and needs nothing further.
// The back end sends one result per cycle while rsp_stall is low, and an item yields
// up to six results; the result port sets the sustained rate.
// A two-entry job queue lets requests keep coming while results are stalled;
// req_stall rises only when the queue is full.
// Reset returns the decode position to the root and empties queue and output.

module morse_codec_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  mc_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output mc_pkg::rsp_t rsp
);

	mc_pkg::qstat_t qstat;
	mc_pkg::job_t   push_job;
	mc_pkg::job_t   head_job;
	logic           push;
	logic           pop;

	mc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.job       (push_job)
	);

	mc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.qstat    (qstat)
	);

	mc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_job  (head_job),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the Morse codec: directed table, random words and a tree predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int DIRECTED_ROWS = 25;
	localparam int ITEM_TARGET = 180;
	localparam int QUIET_ITEMS = 15;
	localparam int HOLD_ITEMS = 10;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_CAP = 30;
	localparam mc_pkg::rsp_t NO_RSP = '0;

	// One row of the directed script; a typed row carries its single expected result.
	typedef struct {
		mc_pkg::req_t req;
		bit           typed;
		mc_pkg::rsp_t want;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         req_valid;
	logic         req_stall;
	mc_pkg::req_t req;
	logic         rsp_valid;
	logic         rsp_stall;
	mc_pkg::rsp_t rsp;

	// Tree nodes in level order; underscore marks a node with no letter.
	string tree_letters = "*ETIANMSURWDKGOHVF_L_PJBXCYZQ__54_3___2_______16_______7___8_90";

	logic [5:0]   tree_pos;
	mc_pkg::rsp_t burst[$];
	mc_pkg::rsp_t expected_chars[$];
	row_t         script[DIRECTED_ROWS];

	bit           cur_typed;
	mc_pkg::rsp_t cur_want;
	bit           quiet;
	bit           hold_request;
	bit           holding;

	int busy_items;
	int n_decode;
	int n_encode;
	int n_results;
	int n_errors;
	int n_input_stalls;
	int n_mismatches;
	int idle_cycles;

	morse_codec_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic mc_pkg::req_t dec(input logic [7:0] ch, input logic eom);
		mc_pkg::req_t r;
		r.func = mc_pkg::FUNC_DECODE;
		r.in_char = ch;
		r.followed_by_space = 1'b0;
		r.end_of_message = eom;
		return r;
	endfunction

	function automatic mc_pkg::req_t enc(input logic [7:0] ch, input logic fbs);
		mc_pkg::req_t r;
		r.func = mc_pkg::FUNC_ENCODE;
		r.in_char = ch;
		r.followed_by_space = fbs;
		r.end_of_message = 1'b0;
		return r;
	endfunction

	function automatic mc_pkg::rsp_t sole_char(input logic [7:0] ch, input logic err);
		mc_pkg::rsp_t r;
		r.out_char = ch;
		r.last_of_run = 1'b1;
		r.error = err;
		return r;
	endfunction

	function automatic void emit_char(input logic [7:0] ch, input logic err);
		mc_pkg::rsp_t r;
		r.out_char = ch;
		r.last_of_run = 1'b0;
		r.error = err;
		burst.push_back(r);
	endfunction

	// Emits the character of the current node and returns to the root.
	function automatic void flush_node();
		emit_char(tree_letters[tree_pos], 1'b0);
		tree_pos = mc_pkg::ROOT;
	endfunction

	// Works out the characters one transaction produces and advances the tree position.
	function automatic void morse_translate(input mc_pkg::req_t r);
		logic [7:0] c;
		logic [7:0] path[5];
		int node;
		int plen;
		int k;
		burst.delete();
		c = r.in_char;
		if (r.func == mc_pkg::FUNC_DECODE) begin
			if (c == mc_pkg::CH_DOT || c == mc_pkg::CH_DASH) begin
				// A symbol below the deepest level overflows the code.
				if (tree_pos >= mc_pkg::DEEPEST_FIRST) begin
					emit_char(mc_pkg::CH_NUL, 1'b1);
					tree_pos = mc_pkg::ROOT;
				end else begin
					tree_pos = {tree_pos[4:0], 1'b0} +
						((c == mc_pkg::CH_DOT) ? 6'd1 : 6'd2);
					if (r.end_of_message)
						flush_node();
				end
			end else if (c == mc_pkg::CH_SPACE || c == mc_pkg::CH_SLASH) begin
				if (tree_pos != mc_pkg::ROOT) begin
					flush_node();
					if (c == mc_pkg::CH_SLASH)
						emit_char(mc_pkg::CH_SPACE, 1'b0);
				end
			end else if (r.end_of_message && tree_pos != mc_pkg::ROOT) begin
				flush_node();
			end
		end else begin
			if (c >= "a" && c <= "z")
				c = c - 8'd32;
			if (c == mc_pkg::CH_SPACE) begin
				emit_char(mc_pkg::CH_SLASH, 1'b0);
			end else begin
				if (c == mc_pkg::CH_STAR || c == mc_pkg::CH_UNDER) begin
					emit_char(c, 1'b0);
				end else begin
					// Find the node, then walk up to the root collecting symbols.
					node = 0;
					for (k = 1; k < 63; k++) begin
						if (node == 0 && tree_letters[k] != "_" && tree_letters[k] == c)
							node = k;
					end
					plen = 0;
					while (node != 0) begin
						path[plen] = node[0] ? mc_pkg::CH_DOT : mc_pkg::CH_DASH;
						node = (node - 1) / 2;
						plen++;
					end
					for (k = plen - 1; k >= 0; k--)
						emit_char(path[k], 1'b0);
				end
				if (!r.followed_by_space)
					emit_char(mc_pkg::CH_SPACE, 1'b0);
			end
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].last_of_run = 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		n_mismatches++;
		if (n_mismatches <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endtask

	task automatic check_result(input mc_pkg::rsp_t got);
		mc_pkg::rsp_t want;
		n_results++;
		if (got.error === 1'b1)
			n_errors++;
		if (expected_chars.size() == 0) begin
			note_mismatch("unexpected result", 0, int'(got));
		end else begin
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char)
				note_mismatch("out_char", int'(want.out_char), int'(got.out_char));
			if (got.last_of_run !== want.last_of_run)
				note_mismatch("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
			if (got.error !== want.error)
				note_mismatch("error", int'(want.error), int'(got.error));
		end
	endtask

	// Requests are predicted before results are checked, so a same-edge result finds its entry.
	always @(posedge clk) begin
		logic [5:0] prior;
		if (arst_n === 1'b1) begin
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				prior = tree_pos;
				morse_translate(req);
				if (burst.size() != 0 || tree_pos != prior)
					busy_items++;
				if (req.func == mc_pkg::FUNC_DECODE)
					n_decode++;
				else
					n_encode++;
				if (cur_typed)
					expected_chars.push_back(cur_want);
				else
					foreach (burst[i])
						expected_chars.push_back(burst[i]);
			end else if (req_valid === 1'b1) begin
				n_input_stalls++;
			end
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				check_result(rsp);
		end
	end

	// Watchdog: too many cycles without any transaction ends the run.
	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side pacing: random stalls, a quiet mode and one long hold-off on request.
	initial begin : result_pacing
		int run;
		logic hold;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holding = 1'b1;
				hold = 1'b1;
				run = HOLD_CYCLES;
			end else begin
				holding = 1'b0;
				if (quiet) begin
					hold = 1'b0;
					run = 1;
				end else if ($urandom_range(0, 99) < 60) begin
					hold = 1'b0;
					run = $urandom_range(1, 8);
				end else begin
					hold = 1'b1;
					run = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) :
						$urandom_range(10, 30);
				end
			end
			rsp_stall <= hold;
			repeat (run) @(negedge clk);
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || holding)
			return 0;
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input mc_pkg::req_t r, input int gap, input bit typed,
			input mc_pkg::rsp_t want);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		cur_want = want;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_chars.size() != 0);
	endtask

	function automatic logic [7:0] pick_text_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return 8'("A" + $urandom_range(0, 25));
		if (roll < 55)
			return 8'("a" + $urandom_range(0, 25));
		if (roll < 75)
			return 8'("0" + $urandom_range(0, 9));
		if (roll < 83)
			return mc_pkg::CH_SPACE;
		if (roll < 88)
			return $urandom_range(0, 1) ? mc_pkg::CH_STAR : mc_pkg::CH_UNDER;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_encode_char();
		mc_pkg::req_t r;
		r = enc(pick_text_char(), $urandom_range(0, 2) == 0);
		r.end_of_message = 1'($urandom_range(0, 1));
		send_item(r, pick_gap(), 1'b0, NO_RSP);
	endtask

	// A well-formed code word: up to five symbols, sometimes an overflowing sixth.
	task automatic send_decode_word();
		int len;
		int k;
		bit eom_end;
		mc_pkg::req_t r;
		len = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
		eom_end = ($urandom_range(0, 3) == 0);
		for (k = 0; k < len; k++) begin
			r = dec($urandom_range(0, 1) ? mc_pkg::CH_DOT : mc_pkg::CH_DASH,
				(k == len - 1) && eom_end);
			r.followed_by_space = 1'($urandom_range(0, 1));
			send_item(r, pick_gap(), 1'b0, NO_RSP);
		end
		if (!eom_end) begin
			r = dec($urandom_range(0, 1) ? mc_pkg::CH_SPACE : mc_pkg::CH_SLASH,
				1'($urandom_range(0, 1)));
			r.followed_by_space = 1'($urandom_range(0, 1));
			send_item(r, pick_gap(), 1'b0, NO_RSP);
		end
	endtask

	task automatic send_word();
		int roll;
		mc_pkg::req_t r;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			send_decode_word();
		end else if (roll < 88) begin
			send_encode_char();
		end else begin
			// Noise: any byte, any function, any flags.
			r.func = 1'($urandom_range(0, 1));
			r.in_char = 8'($urandom_range(0, 255));
			r.followed_by_space = 1'($urandom_range(0, 1));
			r.end_of_message = 1'($urandom_range(0, 1));
			send_item(r, pick_gap(), 1'b0, NO_RSP);
		end
	endtask

	// Main sequence: reset, directed table, pause, quiet stretch, hold-off, random traffic.
	initial begin
		int k;
		int target;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		tree_pos = mc_pkg::ROOT;
		cur_typed = 1'b0;
		cur_want = NO_RSP;
		quiet = 1'b0;
		hold_request = 1'b0;
		holding = 1'b0;
		busy_items = 0;
		n_decode = 0;
		n_encode = 0;
		n_results = 0;
		n_errors = 0;
		n_input_stalls = 0;
		n_mismatches = 0;
		idle_cycles = 0;

		script = '{
			'{dec(mc_pkg::CH_SPACE, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_SLASH, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b1), 1'b1, sole_char("E", 1'b0)},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DASH, 1'b0), 1'b1, sole_char(mc_pkg::CH_NUL, 1'b1)},
			'{dec(mc_pkg::CH_DASH, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_SLASH, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DOT, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DASH, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_DASH, 1'b0), 1'b0, NO_RSP},
			'{dec(mc_pkg::CH_SPACE, 1'b0), 1'b1, sole_char(mc_pkg::CH_UNDER, 1'b0)},
			'{dec(mc_pkg::CH_DASH, 1'b0), 1'b0, NO_RSP},
			'{dec(8'hFF, 1'b1), 1'b1, sole_char("T", 1'b0)},
			'{enc("a", 1'b0), 1'b0, NO_RSP},
			'{enc(mc_pkg::CH_SPACE, 1'b0), 1'b1, sole_char(mc_pkg::CH_SLASH, 1'b0)},
			'{enc("0", 1'b1), 1'b0, NO_RSP},
			'{enc(mc_pkg::CH_NUL, 1'b1), 1'b0, NO_RSP},
			'{enc(8'hFF, 1'b0), 1'b1, sole_char(mc_pkg::CH_SPACE, 1'b0)},
			'{enc(mc_pkg::CH_UNDER, 1'b0), 1'b0, NO_RSP},
			'{enc(mc_pkg::CH_STAR, 1'b1), 1'b1, sole_char(mc_pkg::CH_STAR, 1'b0)}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		for (k = 0; k < DIRECTED_ROWS; k++)
			send_item(script[k].req, pick_gap(), script[k].typed, script[k].want);

		// The sender pauses until the block has delivered everything.
		wait_for_results();

		// A stretch with no idling on either side.
		quiet = 1'b1;
		target = busy_items + QUIET_ITEMS;
		while (busy_items < target)
			send_word();
		quiet = 1'b0;

		// The receiver holds off while encodes keep arriving, so the input backs up.
		hold_request = 1'b1;
		wait (holding === 1'b1);
		for (k = 0; k < HOLD_ITEMS; k++)
			send_encode_char();

		// Random traffic.
		while (busy_items < ITEM_TARGET)
			send_word();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d decode and %0d encode transactions, %0d results, %0d overflows.",
			n_decode, n_encode, n_results, n_errors);
		$display("Input was held back for %0d cycles; %0d mismatches seen.",
			n_input_stalls, n_mismatches);
		if (n_mismatches == 0 && expected_chars.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/mc_pkg.sv
design/mc_front.sv
design/mc_queue.sv
design/mc_back.sv
design/morse_codec_top.sv
tb/testbench.sv
